// ===== hw/rtl/fmxc_pkg.sv =====
// Shared types and constants of the fmix64 keystream XOR cipher.
// Used by fmxc_ctrl, fmxc_dp and the top level; no dependencies.
package fmxc_pkg;

  localparam int unsigned KEY_LENGTH_DEF = 64;
  localparam int unsigned KEY_LENGTH_MAX = 64;

  localparam logic [63:0] GOLDEN_CONST = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL_A        = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] MUL_B        = 64'hC4CE_B9FE_1A85_EC53;
  localparam int unsigned SHIFT_AMT    = 33;
  localparam logic [7:0]  POS_MUL      = 8'd137;

  // Controller-to-datapath command group
  typedef struct packed {
    logic load;         // accept an item: latch byte, reload or continue chain
    logic sel_x_hi;     // multiplier operand: upper half of chain value
    logic sel_c_hi;     // multiplier operand: upper half of constant
    logic sel_const_b;  // second multiply of the round
    logic acc_load;     // acc <= low partial product
    logic acc_add;      // acc += cross product << 32
    logic x_update;     // finish multiply, apply xor-shift into chain value
    logic out_load;     // write result into output register
  } cmd_t;

endpackage

// ===== hw/rtl/fmxc_ctrl.sv =====
// Sequencer of the fmix64 keystream cipher: handshakes and multiply steps.
// Depends on fmxc_pkg (cmd_t).
module fmxc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output fmxc_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] K_LL   = 2'd0;
  localparam logic [1:0] K_LH   = 2'd1;
  localparam logic [1:0] K_HL   = 2'd2;
  localparam logic [1:0] K_LAST = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [2:0] step;
  logic       out_free;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd             = '0;
    state_next      = state;
    cmd.load        = s_tvalid && s_tready;
    cmd.sel_const_b = step[2];
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_MUL;
      end
      ST_MUL: begin
        unique case (step[1:0])
          K_LL: begin
          end
          K_LH: begin
            cmd.sel_c_hi = 1'b1;
            cmd.acc_load = 1'b1;
          end
          K_HL: begin
            cmd.sel_x_hi = 1'b1;
            cmd.acc_add  = 1'b1;
          end
          K_LAST: begin
            cmd.x_update = 1'b1;
          end
        endcase
        if (step == 3'd7) state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_MUL) step <= step + 3'd1;
      else step <= '0;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/fmxc_dp.sv =====
// Datapath of the fmix64 keystream cipher: seed, chain value, positions,
// one shared 32x32 multiplier with accumulator, output register. Uses fmxc_pkg.
module fmxc_dp #(
  parameter int unsigned KEY_LENGTH = fmxc_pkg::KEY_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  fmxc_pkg::cmd_t     cmd,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  logic [7:0]         data_byte,
  input  logic               start_region,
  output logic [7:0]         out_byte
);

  localparam int unsigned KP_W = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
  localparam logic [KP_W-1:0] KP_LAST = KP_W'(KEY_LENGTH - 1);

  logic [63:0]     key_seed;
  logic [63:0]     x;          // chain value, holds mix state between items
  logic [63:0]     acc;
  logic [63:0]     prod;
  logic [KP_W-1:0] key_position;
  logic [7:0]      byte_position;
  logic [7:0]      data_q;
  logic [7:0]      pos_term;

  logic [KP_W-1:0] kp_eff;
  logic [7:0]      bp_eff;
  logic [63:0]     base;
  logic [63:0]     mul_const;
  logic [31:0]     op_x;
  logic [31:0]     op_c;
  logic [63:0]     sum;

  assign kp_eff    = start_region ? '0 : key_position;
  assign bp_eff    = start_region ? '0 : byte_position;
  assign base      = (kp_eff == '0) ? (key_seed ^ fmxc_pkg::GOLDEN_CONST) : x;
  assign mul_const = cmd.sel_const_b ? fmxc_pkg::MUL_B : fmxc_pkg::MUL_A;
  assign op_x      = cmd.sel_x_hi ? x[63:32] : x[31:0];
  assign op_c      = cmd.sel_c_hi ? mul_const[63:32] : mul_const[31:0];
  assign sum       = acc + {prod[31:0], 32'h0};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed      <= '0;
      key_position  <= '0;
      byte_position <= '0;
    end else begin
      if (cfg_we) key_seed <= cfg_wdata;
      if (cmd.load) begin
        key_position  <= (kp_eff == KP_LAST) ? '0 : kp_eff + KP_W'(1);
        byte_position <= bp_eff + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(op_x) * 64'(op_c);
    if (cmd.load) begin
      x        <= base ^ (base >> fmxc_pkg::SHIFT_AMT);
      data_q   <= data_byte;
      pos_term <= bp_eff * fmxc_pkg::POS_MUL;
    end else if (cmd.x_update) begin
      x <= sum ^ (sum >> fmxc_pkg::SHIFT_AMT);
    end
    if (cmd.acc_load) acc <= prod;
    else if (cmd.acc_add) acc <= sum;
    if (cmd.out_load) out_byte <= data_q ^ x[7:0] ^ pos_term;
  end

endmodule

// ===== hw/rtl/fmix64_keystream_xor_cipher_unit.sv =====
// Top level of the fmix64 keystream XOR byte cipher.
// Instantiates fmxc_ctrl and fmxc_dp; uses fmxc_pkg.

// Symmetric byte cipher: every transfer on the slave side yields exactly one
// byte on the master side, out = data ^ keystream byte ^ low byte of
// (position * 137); the same operation encrypts and decrypts. The keystream
// is a chain of fmix64 rounds started from key_seed ^ 0x9E3779B97F4A7C15 and
// restarted every KEY_LENGTH bytes and at each region start (s_tuser high).
// Write key_seed through cfg_we/cfg_wdata while the block is idle; a new seed
// takes effect at the next chain reload. Each byte is taken, passes through the
// two 64-bit multiplies of the round (each built from three partial products on
// one shared 32x32 multiplier with a registered product), and is written to the
// output register once that register is free; no new byte is taken before this.
// The output register frees the slave side, so the next byte can be taken while
// the last result still waits for m_tready.
module fmix64_keystream_xor_cipher_unit #(
  parameter int unsigned KEY_LENGTH = fmxc_pkg::KEY_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,   // key_seed
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] data_byte
  input  logic        s_tuser,     // [0] start_region
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata      // [7:0] out_byte
);

  fmxc_pkg::cmd_t cmd;

  // Sequence the handshakes and the multiply steps
  fmxc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // Hold seed, chain and positions; compute the round and the output byte
  fmxc_dp #(
    .KEY_LENGTH (KEY_LENGTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .data_byte    (s_tdata),
    .start_region (s_tuser),
    .out_byte     (m_tdata)
  );

  // One byte in flight: slave side closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("slave side ready while an item is in flight");

  // Both multiplies finish at fixed steps after the transfer
  a_round_timing: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##4 cmd.x_update ##4 cmd.x_update)
    else $error("multiply sequence out of step");

  // A result written to the output register is offered next cycle
  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("output register loaded but not valid");

endmodule

// ===== tb/fmix64_keystream_xor_cipher_unit_tb.sv =====
// Self-checking testbench of the fmix64 keystream XOR byte cipher.
// Depends on fmxc_pkg and fmix64_keystream_xor_cipher_unit (which brings in fmxc_ctrl and fmxc_dp).
// Streams bytes through the block and checks each output against a local predictor.
`timescale 1ns / 1ps

module fmix64_keystream_xor_cipher_unit_tb;

  localparam int unsigned KEY_LEN    = fmxc_pkg::KEY_LENGTH_DEF;
  localparam int unsigned CYCLE_MAX  = 400000;  // watchdog limit for a hung run
  localparam int unsigned HOLD_AT    = 700;     // transfer count that triggers the long stall
  localparam int unsigned HOLD_LEN   = 500;     // cycles the output side stays stalled
  localparam int unsigned RAND_PHASE = 250;     // least number of bytes per random phase

  // One byte to send, with the idle cycles that follow its transfer. A drain
  // byte is held back until every outstanding result has come out.
  typedef struct {
    logic [7:0] data;
    logic       start;
    logic [2:0] gap;
    logic       drain;
  } tx_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;       // [7:0] data_byte
  logic        s_tuser = 1'b0;     // [0] start_region
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;            // [7:0] out_byte

  tx_byte_t    pending_bytes[$];
  logic [7:0]  expected_bytes[$];

  // Predictor state: seed register, keystream chain, slot in the key period,
  // low byte of the region position.
  logic [63:0] seed_shadow  = '0;
  logic [63:0] chain_shadow = '0;
  int unsigned key_slot     = 0;
  logic [7:0]  region_pos   = '0;

  int unsigned accepted   = 0;
  int unsigned checked    = 0;
  int unsigned fail_count = 0;
  int unsigned seed_count = 0;
  int unsigned cycles     = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;
  logic        rx_fast    = 1'b0;
  logic [2:0]  tx_wait    = '0;
  logic [2:0]  tx_gap_cur = '0;
  logic [2:0]  rx_wait    = '0;

  fmix64_keystream_xor_cipher_unit #(
    .KEY_LENGTH(KEY_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // One finalizer round of the keystream chain.
  function automatic logic [63:0] fmix_round(logic [63:0] v);
    v = v ^ (v >> fmxc_pkg::SHIFT_AMT);
    v = v * fmxc_pkg::MUL_A;
    v = v ^ (v >> fmxc_pkg::SHIFT_AMT);
    v = v * fmxc_pkg::MUL_B;
    v = v ^ (v >> fmxc_pkg::SHIFT_AMT);
    return v;
  endfunction

  // Advance the predictor by one byte and return the cipher output.
  function automatic logic [7:0] cipher_byte(logic [7:0] data, logic start);
    logic [7:0] pos_term;
    if (start) begin
      key_slot   = 0;
      region_pos = '0;
    end
    // reload the chain at a region start and at every key-period wrap
    if (key_slot == 0)
      chain_shadow = seed_shadow ^ fmxc_pkg::GOLDEN_CONST;
    chain_shadow = fmix_round(chain_shadow);
    pos_term     = region_pos * fmxc_pkg::POS_MUL;
    region_pos   = region_pos + 8'd1;
    key_slot     = (key_slot + 1 == KEY_LEN) ? 0 : key_slot + 1;
    return data ^ chain_shadow[7:0] ^ pos_term;
  endfunction

  // Driver: predict each transfer on the input side, then either hold the
  // offered byte, idle for its gap, or offer the next pending byte.
  always @(posedge clk) begin : drive
    logic       fire;
    logic [2:0] wait_now;
    logic [7:0] pred;
    fire     = s_tvalid && s_tready;
    wait_now = tx_wait;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait  <= '0;
    end else begin
      if (fire) begin
        pred = cipher_byte(s_tdata, s_tuser);
        expected_bytes.insert(expected_bytes.size(), pred);
        accepted <= accepted + 1;
        wait_now = tx_gap_cur;
      end
      if (s_tvalid && !fire) begin
        // hold data stable until the block takes it
      end else if (wait_now != 0) begin
        s_tvalid <= 1'b0;
        tx_wait  <= wait_now - 3'd1;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].drain && expected_bytes.size() != 0)) begin
        s_tvalid   <= 1'b1;
        s_tdata    <= pending_bytes[0].data;
        s_tuser    <= pending_bytes[0].start;
        tx_gap_cur <= pending_bytes[0].gap;
        tx_wait    <= '0;
        void'(pending_bytes.pop_front());
      end else begin
        s_tvalid <= 1'b0;
        tx_wait  <= '0;
      end
    end
  end

  // Long output stall: once enough bytes have gone in, drop m_tready for a
  // long stretch while the driver keeps offering, so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Monitor: compare every output transfer with the oldest prediction, then
  // draw the stall that follows it.
  always @(posedge clk) begin : watch
    logic [2:0] wait_now;
    logic [7:0] want;
    wait_now = rx_wait;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected none, actual %02h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want) begin
            $error("out_byte: expected %02h, actual %02h", want, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
        checked  <= checked + 1;
        wait_now = rx_fast ? 3'd0 : 3'($urandom_range(0, 7));
      end
      if (wait_now != 0) begin
        m_tready <= 1'b0;
        rx_wait  <= wait_now - 3'd1;
      end else begin
        m_tready <= (hold_left == 0);
        rx_wait  <= '0;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_MAX) begin
      $display("fmix64_keystream_xor_cipher_unit_tb: errors");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] data, logic start, logic [2:0] gap, logic drain);
    tx_byte_t b;
    b.data  = data;
    b.start = start;
    b.gap   = gap;
    b.drain = drain;
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  // Wait until the block has emptied: nothing queued, nothing offered, no
  // result outstanding, plus a few cycles of margin.
  task automatic settle();
    while (pending_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write key_seed while idle; the predictor takes the seed as cfg_we is driven, before the block registers it.
  task automatic write_seed(logic [63:0] seed);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= seed;
    seed_shadow = seed;
    seed_count++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] phase_seed[6];
    int unsigned n;
    int unsigned len;
    logic        region_fast;
    logic        st;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Seed left at reset value; first byte comes without a region start.
    add_byte(8'h00, 1'b0, 3'd0, 1'b0);
    add_byte(8'hFF, 1'b0, 3'd2, 1'b0);
    add_byte(8'h01, 1'b0, 3'd0, 1'b0);
    add_byte(8'h80, 1'b0, 3'd7, 1'b0);
    add_byte(8'h55, 1'b0, 3'd0, 1'b0);
    add_byte(8'hAA, 1'b1, 3'd0, 1'b0);
    add_byte(8'h3C, 1'b0, 3'd1, 1'b0);
    add_byte(8'hFF, 1'b1, 3'd0, 1'b0);
    settle();

    // All-ones seed written mid-period: the chain keeps running on the old
    // seed until the region start below reloads it.
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    add_byte(8'h00, 1'b0, 3'd0, 1'b0);
    add_byte(8'hFF, 1'b0, 3'd3, 1'b0);
    add_byte(8'h7E, 1'b0, 3'd0, 1'b0);
    add_byte(8'h00, 1'b1, 3'd0, 1'b0);
    add_byte(8'hFF, 1'b0, 3'd0, 1'b0);
    add_byte(8'h81, 1'b1, 3'd5, 1'b0);
    add_byte(8'hC3, 1'b0, 3'd0, 1'b0);
    settle();

    // Seed equal to the golden constant: the chain starts from zero.
    write_seed(fmxc_pkg::GOLDEN_CONST);
    add_byte(8'h00, 1'b1, 3'd0, 1'b0);
    add_byte(8'hFF, 1'b0, 3'd0, 1'b0);
    add_byte(8'h5A, 1'b0, 3'd4, 1'b0);
    add_byte(8'hA5, 1'b1, 3'd0, 1'b0);
    add_byte(8'h0F, 1'b0, 3'd0, 1'b0);
    add_byte(8'hF0, 1'b0, 3'd0, 1'b0);
    settle();

    // Random phases: regions of random length, now and then long enough to
    // wrap the position byte and several key periods.
    phase_seed[0] = {$urandom, $urandom};
    phase_seed[1] = 64'h0000_0000_0000_0000;
    phase_seed[2] = {$urandom, $urandom};
    phase_seed[3] = 64'h8000_0000_0000_0001;
    phase_seed[4] = {$urandom, $urandom};
    phase_seed[5] = 64'hFFFF_FFFF_FFFF_FFFF;
    for (int p = 0; p < 6; p++) begin
      write_seed(phase_seed[p]);
      rx_fast <= ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < RAND_PHASE) begin
        len         = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(1, 80);
        region_fast = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          // usually open a region with a start; rarely drop one in mid-region
          st = (i == 0) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 99) == 0);
          add_byte(8'($urandom), st,
                   region_fast ? 3'd0 : 3'($urandom_range(0, 7)),
                   (p == 2 && n == 120));
          n++;
        end
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("%0d bytes enciphered over %0d key seeds, %0d outputs compared,",
             accepted, seed_count, checked);
    $display("including position wraps, key-period wraps, a long output stall and a drain pause");
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("fmix64_keystream_xor_cipher_unit_tb: clean");
    end else begin
      $display("fmix64_keystream_xor_cipher_unit_tb: errors");
    end
    $finish;
  end

endmodule
